// File: hw/rtl/rmv_pkg.sv
package rmv_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  localparam int MEAN_W   = SAMPLE_BITS + FRACTION_BITS;
  localparam int SQ_W     = 2 * SAMPLE_BITS + FRACTION_BITS - 1;
  localparam int DIV_W    = SQ_W;
  localparam int DIFF_W   = SQ_W + 1;
  localparam int PROD_W   = 2 * MEAN_W;
  localparam int MSQ_CMP_W = PROD_W - FRACTION_BITS;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  localparam int OUT_BITS = MEAN_W + SQ_W + COUNT_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic DIV_SEL_MEAN = 1'b0;
  localparam logic DIV_SEL_SQ   = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic apply_mean;
    logic apply_sq;
    logic mult;
    logic finish;
  } rmv_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic div_done;
    logic out_free;
  } rmv_status_t;

endpackage

// File: hw/rtl/rmv_div.sv
module rmv_div import rmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [COUNT_BITS-1:0] rem;
  logic [DIV_W-1:0]      quo;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   rem_sub;
  logic                  ge;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/rmv_datapath.sv
module rmv_datapath import rmv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  rmv_cmd_t               cmd,
  output rmv_status_t            status,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MEAN_W-1:0]      mean_value,
  output logic [SQ_W-1:0]        variance_value,
  output logic [COUNT_BITS-1:0]  samples_used,
  output logic                   count_overflow
);

  logic signed [MEAN_W-1:0] mean;
  logic [SQ_W-1:0]          msq;
  logic [COUNT_BITS-1:0]    count;
  logic                     ovf;
  logic [SAMPLE_BITS-1:0]   x;
  logic                     last;
  logic                     full;
  logic                     neg;
  logic [PROD_W-1:0]        prod;

  logic signed [2*SAMPLE_BITS-1:0] x_sq;
  logic signed [DIFF_W-1:0]        x_scaled;
  logic signed [DIFF_W-1:0]        diff_m;
  logic signed [DIFF_W-1:0]        diff_s;
  logic signed [DIFF_W-1:0]        diff_sel;
  logic [DIFF_W-1:0]               diff_mag;
  logic [DIV_W-1:0]                quotient;
  logic                            div_done;
  logic [DIFF_W-1:0]               q_signed;
  logic [MEAN_W-1:0]               mean_mag;
  logic [MSQ_CMP_W-1:0]            mean_sq;
  logic [MSQ_CMP_W-1:0]            msq_ext;
  logic [MSQ_CMP_W-1:0]            var_full;

  assign x_sq     = $signed(x) * $signed(x);
  assign x_scaled = {{(DIFF_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x} <<< FRACTION_BITS;
  assign diff_m   = x_scaled - {{(DIFF_W-MEAN_W){mean[MEAN_W-1]}}, mean};
  assign diff_s   = ({{(DIFF_W-2*SAMPLE_BITS){1'b0}}, x_sq} << FRACTION_BITS)
                    - {{(DIFF_W-SQ_W){1'b0}}, msq};
  assign diff_sel = (cmd.div_sel == DIV_SEL_SQ) ? diff_s : diff_m;
  assign diff_mag = diff_sel[DIFF_W-1] ? DIFF_W'(-diff_sel) : diff_sel;

  rmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff_mag[DIV_W-1:0]),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_signed = neg ? DIFF_W'(-{1'b0, quotient}) : {1'b0, quotient};

  assign mean_mag = mean[MEAN_W-1] ? MEAN_W'(-mean) : mean;
  assign mean_sq  = prod[PROD_W-1:FRACTION_BITS];
  assign msq_ext  = {{(MSQ_CMP_W-SQ_W){1'b0}}, msq};
  assign var_full = (msq_ext > mean_sq) ? (msq_ext - mean_sq) : '0;

  assign status.full     = full;
  assign status.last     = last;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean  <= '0;
      msq   <= '0;
      count <= '0;
      ovf   <= 1'b0;
      full  <= 1'b0;
      last  <= 1'b0;
    end else if (cmd.finish) begin
      mean  <= '0;
      msq   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.load) begin
        last <= last_sample;
        if (count == COUNT_MAX) begin
          ovf  <= 1'b1;
          full <= 1'b1;
        end else begin
          count <= count + COUNT_BITS'(1);
          full  <= 1'b0;
        end
      end
      if (cmd.apply_mean) begin
        mean <= mean + $signed(q_signed[MEAN_W-1:0]);
      end
      if (cmd.apply_sq) begin
        msq <= msq + q_signed[SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sample_value;
    end
    if (cmd.div_start) begin
      neg <= diff_sel[DIFF_W-1];
    end
    if (cmd.mult) begin
      prod <= mean_mag * mean_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mean_value     <= mean;
      variance_value <= var_full[SQ_W-1:0];
      samples_used   <= count;
      count_overflow <= ovf;
    end
  end

endmodule

// File: hw/rtl/rmv_ctrl.sv
module rmv_ctrl import rmv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rmv_status_t status,
  output rmv_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_DIVM = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_MULT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (status.full) begin
          state_next = status.last ? ST_MULT : ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_MEAN;
          state_next    = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (status.div_done) begin
          cmd.apply_mean = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = DIV_SEL_SQ;
          state_next     = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (status.div_done) begin
          cmd.apply_sq = 1'b1;
          state_next   = status.last ? ST_MULT : ST_IDLE;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/running_mean_variance.sv
// One beat at a time: s_tready stays low until the shared bit-serial divider has run once
//   for the mean and once for the mean square, so no new sample is taken before then.
// A beat past the count limit skips the divider; a last beat adds steps for the squared
//   mean (ST_MULT) and the output register (ST_OUT).
// The result of a last beat is held back by any stall on the output side.
// Reset (rst, synchronous, active high) clears the running state and the output valid.
module running_mean_variance import rmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] sample_value
  input  logic                  s_tlast,   // last_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // mean_value, variance_value, samples_used, zero pad
  output logic                  m_tuser    // count_overflow
);

  rmv_cmd_t              cmd;
  rmv_status_t           status;
  logic [MEAN_W-1:0]     mean_value;
  logic [SQ_W-1:0]       variance_value;
  logic [COUNT_BITS-1:0] samples_used;

  rmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rmv_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_value   (s_tdata[SAMPLE_BITS-1:0]),
    .last_sample    (s_tlast),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .mean_value     (mean_value),
    .variance_value (variance_value),
    .samples_used   (samples_used),
    .count_overflow (m_tuser)
  );

  assign m_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}}, samples_used, variance_value, mean_value};

endmodule

// File: bench/tb_running_mean_variance.sv
`timescale 1ns / 1ps

module tb_running_mean_variance;
  import rmv_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
  } sample_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0]     mean;
    logic [SQ_W-1:0]       variance;
    logic [COUNT_BITS-1:0] used;
    logic                  overflow;
  } set_stats_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  running_mean_variance dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_beat_t pending_samples[$];
  set_stats_t   stats_due[$];
  int           fail_count = 0;
  int           accepted_items = 0;

  longint       acc_mean = 0;
  longint       acc_msq = 0;
  int unsigned  acc_count = 0;
  bit           acc_ovf = 1'b0;

  task automatic fold_sample(input sample_beat_t b);
    longint             x;
    longint             diff;
    longint unsigned    mag;
    longint unsigned    mean_sq;
    longint unsigned    var_v;
    set_stats_t         r;
    x = longint'($signed(b.value));
    if (acc_count >= int'(COUNT_MAX)) begin
      acc_ovf = 1'b1;
    end else begin
      acc_count = acc_count + 1;
      diff = x * (longint'(1) << FRACTION_BITS) - acc_mean;
      acc_mean = acc_mean + diff / longint'(acc_count);
      diff = x * x * (longint'(1) << FRACTION_BITS) - acc_msq;
      acc_msq = acc_msq + diff / longint'(acc_count);
    end
    if (b.last) begin
      mag = (acc_mean < 0) ? longint'(-acc_mean) : acc_mean;
      mean_sq = (mag * mag) >> FRACTION_BITS;
      var_v = (longint'(acc_msq) > longint'(mean_sq)) ? longint'(acc_msq) - mean_sq : 0;
      r.mean = acc_mean[MEAN_W-1:0];
      r.variance = var_v[SQ_W-1:0];
      r.used = acc_count[COUNT_BITS-1:0];
      r.overflow = acc_ovf;
      stats_due.push_back(r);
      acc_mean = 0;
      acc_msq = 0;
      acc_count = 0;
      acc_ovf = 1'b0;
    end
  endtask

  task automatic queue_sample(input logic [SAMPLE_BITS-1:0] v, input logic l);
    sample_beat_t b;
    b.value = v;
    b.last = l;
    pending_samples.push_back(b);
  endtask

  task automatic queue_random_set(input int len, input int style);
    int base;
    int v;
    base = int'($urandom_range(0, 65534)) - 32768;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = int'($urandom_range(0, 65535));
        1: begin
          case ($urandom_range(0, 4))
            0: v = 32767;
            1: v = -32768;
            2: v = -1;
            3: v = 0;
            default: v = 1;
          endcase
        end
        default: v = base + int'($urandom_range(0, 1));
      endcase
      queue_sample(v[SAMPLE_BITS-1:0], i == len - 1);
    end
  endtask

  // input side
  sample_beat_t live_beat;
  logic         offer;
  int           hold_left = 0;
  bit           wait_on_ready = 1'b0;
  bit           calm_in = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      hold_left = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        fold_sample(live_beat);
        accepted_items = accepted_items + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (hold_left != 0) begin
          if (s_tready || !wait_on_ready) hold_left = hold_left - 1;
        end else if (pending_samples.size() != 0) begin
          live_beat = pending_samples.pop_front();
          s_tdata <= IN_DATA_W'(live_beat.value);
          s_tlast <= live_beat.last;
          offer = 1'b1;
          if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
          hold_left = calm_in ? 0 : int'($urandom_range(0, 5));
          wait_on_ready = ($urandom_range(0, 1) == 1);
        end
      end
      s_tvalid <= offer;
    end
  end

  // output side
  set_stats_t             want;
  logic [MEAN_W-1:0]      got_mean;
  logic [SQ_W-1:0]        got_var;
  logic [COUNT_BITS-1:0]  got_used;
  int                     stall_left = 0;
  bit                     calm_out = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_mean = m_tdata[MEAN_W-1:0];
        got_var = m_tdata[MEAN_W +: SQ_W];
        got_used = m_tdata[MEAN_W+SQ_W +: COUNT_BITS];
        if (stats_due.size() == 0) begin
          $error("unexpected result beat: mean_value %0d samples_used %0d",
                 $signed(got_mean), got_used);
          fail_count++;
        end else begin
          want = stats_due.pop_front();
          if (got_mean !== want.mean) begin
            $error("mean_value expected %0d got %0d", $signed(want.mean), $signed(got_mean));
            fail_count++;
          end
          if (got_var !== want.variance) begin
            $error("variance_value expected %0d got %0d", want.variance, got_var);
            fail_count++;
          end
          if (got_used !== want.used) begin
            $error("samples_used expected %0d got %0d", want.used, got_used);
            fail_count++;
          end
          if (m_tuser !== want.overflow) begin
            $error("count_overflow expected %0d got %0d", want.overflow, m_tuser);
            fail_count++;
          end
        end
        if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
        stall_left = calm_out ? 0 : int'($urandom_range(0, 5));
      end else if (m_tvalid && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      m_tready <= (stall_left == 0);
    end
  end

  initial begin
    #150_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int random_items;
    int len;
    int total_items;
    random_items = 0;

    queue_sample(16'sh7fff, 1'b1);
    queue_sample(16'sh8000, 1'b1);
    queue_sample(16'sh0000, 1'b1);
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    // negative mean, truncation toward zero
    queue_sample(16'shffff, 1'b0);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(16'sh0000, 1'b1);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    // nearly constant large samples: rounding can push the variance below zero
    queue_sample(16'd30001, 1'b0);
    queue_sample(16'd30000, 1'b0);
    queue_sample(16'd30000, 1'b0);
    queue_sample(16'd30001, 1'b1);
    queue_sample(-16'sd29999, 1'b0);
    queue_sample(-16'sd30000, 1'b0);
    queue_sample(-16'sd30000, 1'b1);
    queue_sample(16'd1, 1'b0);
    queue_sample(16'd2, 1'b0);
    queue_sample(16'd3, 1'b1);

    while (random_items < 1600) begin
      len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(7, 48))
                                        : int'($urandom_range(1, 6));
      queue_random_set(len, int'($urandom_range(0, 2)));
      random_items += len;
    end

    total_items = pending_samples.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items < total_items || stats_due.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
